FILE: hw/rtl/tac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tac_pkg
// Shared constants, types and helpers of the touch average/calibrate block.
// ----------------------------------------------------------------------------
package tac_pkg;

    // Sample averaging
    localparam int SAMPLES     = 4;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    // sum / SAMPLES as a multiply by a truncated reciprocal plus one fix-up
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP       = (1 << RECIP_SHIFT) / SAMPLES;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QFIX_W      = SUM_W + 5;

    // Field widths
    localparam int RAW_W       = 12;
    localparam int SIZE_W      = 11;
    localparam int PIX_W       = 10;
    localparam int AVG_LIMIT   = 4090;

    // Scale product and divider
    localparam int DIFF_W      = RAW_W + 1;
    localparam int MUL_W       = DIFF_W + SIZE_W + 1;
    localparam int MAG_W       = 22;
    localparam int DIV_STEPS   = MAG_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // Register file
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_H_MIN  = 3'd0;
    localparam t_reg_idx REG_H_MAX  = 3'd1;
    localparam t_reg_idx REG_V_MIN  = 3'd2;
    localparam t_reg_idx REG_V_MAX  = 3'd3;
    localparam t_reg_idx REG_WIDTH  = 3'd4;
    localparam t_reg_idx REG_HEIGHT = 3'd5;

    localparam logic [RAW_W-1:0]  RST_H_MIN  = RAW_W'(200);
    localparam logic [RAW_W-1:0]  RST_H_MAX  = RAW_W'(3750);
    localparam logic [RAW_W-1:0]  RST_V_MIN  = RAW_W'(300);
    localparam logic [RAW_W-1:0]  RST_V_MAX  = RAW_W'(3800);
    localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(320);
    localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(240);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(1024);

    typedef struct packed {
        logic [RAW_W-1:0] avg_x;
        logic [RAW_W-1:0] avg_y;
    } t_pair;

    typedef struct packed {
        logic [RAW_W-1:0]  h_min;
        logic [RAW_W-1:0]  h_max;
        logic [RAW_W-1:0]  v_min;
        logic [RAW_W-1:0]  v_max;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_cal;

    typedef enum logic [1:0] {
        F_ACC,
        F_MUL,
        F_FIX
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_START,
        B_WAIT,
        B_OUT
    } t_back_state;

    // Zero acts as one, anything above 1024 as 1024
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (s > SIZE_MAX) begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tac_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tac_fifo
// Short queue of averaged pairs between the front and the back.
// ----------------------------------------------------------------------------
module tac_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  tac_pkg::t_pair     i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output tac_pkg::t_pair     o_data,
    output logic               o_empty
);
    import tac_pkg::*;

    t_pair              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tac_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tac_front
// Accepts sample pairs, sums them per burst and pushes the averages.
// ----------------------------------------------------------------------------
module tac_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic                      i_pen_down,
    input  wire logic [tac_pkg::RAW_W-1:0] i_sample_x,
    input  wire logic [tac_pkg::RAW_W-1:0] i_sample_y,
    output logic                           o_q_push,
    output tac_pkg::t_pair                 o_q_data,
    input  wire logic                      i_q_full
);
    import tac_pkg::*;

    t_front_state       r_state;
    t_front_state       n_state;
    logic [SUM_W-1:0]   r_sum_x;
    logic [SUM_W-1:0]   r_sum_y;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_prod_x;
    logic [PROD_W-1:0]  r_prod_y;
    logic               accept;
    logic               last;
    logic [SUM_W-1:0]   add_x;
    logic [SUM_W-1:0]   add_y;
    logic [SUM_W-1:0]   q_x;
    logic [SUM_W-1:0]   q_y;

    // Quotient estimate is low by at most one
    function automatic logic [SUM_W-1:0] fix_quot(input logic [SUM_W-1:0]  sum,
                                                  input logic [PROD_W-1:0] prod);
        logic [SUM_W-1:0]  q0;
        logic [QFIX_W-1:0] back;
        logic [QFIX_W-1:0] rem;
        q0   = prod[RECIP_SHIFT +: SUM_W];
        back = QFIX_W'(q0) * QFIX_W'(SAMPLES);
        rem  = QFIX_W'(sum) - back;
        return (rem >= QFIX_W'(SAMPLES)) ? q0 + 1'b1 : q0;
    endfunction

    assign accept = i_push && !o_full;
    assign last   = ((CNT_W+1)'(r_cnt) + 1'b1) >= (CNT_W+1)'(SAMPLES);
    assign add_x  = r_sum_x + SUM_W'(i_sample_x);
    assign add_y  = r_sum_y + SUM_W'(i_sample_y);
    assign q_x    = fix_quot(r_sum_x, r_prod_x);
    assign q_y    = fix_quot(r_sum_y, r_prod_y);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_ACC: begin
                if (accept && i_pen_down && last) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: n_state = F_FIX;
            F_FIX: begin
                if (!i_q_full) begin
                    n_state = F_ACC;
                end
            end
            default: n_state = F_ACC;
        endcase
    end

    always_comb begin
        o_full         = (r_state != F_ACC);
        o_q_push       = (r_state == F_FIX) && !i_q_full;
        o_q_data.avg_x = q_x[RAW_W-1:0];
        o_q_data.avg_y = q_y[RAW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_ACC;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (!i_pen_down) begin
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_cnt   <= '0;
                end else begin
                    r_sum_x <= add_x;
                    r_sum_y <= add_y;
                    if (!last) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end else if (o_q_push) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_cnt   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_MUL) begin
            r_prod_x <= PROD_W'(r_sum_x) * PROD_W'(RECIP);
            r_prod_y <= PROD_W'(r_sum_y) * PROD_W'(RECIP);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tac_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tac_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tac_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [tac_pkg::MAG_W-1:0] i_dividend,
    input  wire logic [tac_pkg::RAW_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [tac_pkg::MAG_W-1:0]      o_quot
);
    import tac_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RAW_W-1:0]  r_div;
    logic [RAW_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_quo;
    logic [RAW_W:0]    trial;
    logic              ge;

    assign trial  = {r_rem, r_quo[MAG_W-1]};
    assign ge     = trial >= {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? RAW_W'(trial - {1'b0, r_div}) : trial[RAW_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tac_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tac_back
// Checks averages, scales both axes through the divider, holds the result.
// ----------------------------------------------------------------------------
module tac_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  tac_pkg::t_cal                  i_cal,
    input  wire logic                      i_q_empty,
    input  tac_pkg::t_pair                 i_q_data,
    output logic                           o_q_pop,
    output logic                           o_empty,
    input  wire logic                      i_pop,
    output logic                           o_touch_valid,
    output logic [tac_pkg::RAW_W-1:0]      o_avg_x,
    output logic [tac_pkg::RAW_W-1:0]      o_avg_y,
    output logic [tac_pkg::PIX_W-1:0]      o_screen_x,
    output logic [tac_pkg::PIX_W-1:0]      o_screen_y
);
    import tac_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    logic               r_axis;
    logic [RAW_W-1:0]   r_ax;
    logic [RAW_W-1:0]   r_ay;
    logic               r_valid;
    logic [PIX_W-1:0]   r_px;
    logic [PIX_W-1:0]   r_py;
    logic               r_neg;
    logic [MAG_W-1:0]   r_mag;
    logic [RAW_W-1:0]   r_span;
    logic [SIZE_W-1:0]  r_size;
    logic               r_out_full;
    logic               div_start;
    logic               div_done;
    logic [MAG_W-1:0]   div_quot;
    logic               in_valid;
    logic [RAW_W-1:0]   sel_avg;
    logic [RAW_W-1:0]   sel_min;
    logic [RAW_W-1:0]   sel_max;
    logic [SIZE_W-1:0]  sel_size;
    logic signed [DIFF_W-1:0] diff;
    logic signed [MUL_W-1:0]  prod;
    logic [MUL_W-1:0]   prod_abs;
    logic [SIZE_W-1:0]  pix;

    // Range and calibration check on the queue head
    assign in_valid = (i_q_data.avg_x != '0) && (i_q_data.avg_y != '0)
                   && (i_q_data.avg_x <= RAW_W'(AVG_LIMIT))
                   && (i_q_data.avg_y <= RAW_W'(AVG_LIMIT))
                   && (i_cal.h_max > i_cal.h_min) && (i_cal.v_max > i_cal.v_min);

    // Axis 0: screen X from the Y average; axis 1: screen Y from the X average
    always_comb begin
        if (!r_axis) begin
            sel_avg  = r_ay;
            sel_min  = i_cal.h_min;
            sel_max  = i_cal.h_max;
            sel_size = eff_size(i_cal.width);
        end else begin
            sel_avg  = r_ax;
            sel_min  = i_cal.v_min;
            sel_max  = i_cal.v_max;
            sel_size = eff_size(i_cal.height);
        end
        diff     = $signed({1'b0, sel_avg}) - $signed({1'b0, sel_min});
        prod     = MUL_W'(diff) * $signed({{(MUL_W-SIZE_W){1'b0}}, sel_size});
        prod_abs = prod[MUL_W-1] ? MUL_W'(-prod) : MUL_W'(prod);
    end

    // Inversion and clamp: size - q, limited to 0..size-1
    always_comb begin
        priority if (r_neg || div_quot == '0) begin
            pix = r_size - 1'b1;
        end else if (div_quot >= MAG_W'(r_size)) begin
            pix = '0;
        end else begin
            pix = r_size - div_quot[SIZE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && !r_out_full) begin
                    n_state = in_valid ? B_MUL : B_OUT;
                end
            end
            B_MUL:   n_state = B_START;
            B_START: n_state = B_WAIT;
            B_WAIT: begin
                if (div_done) begin
                    n_state = r_axis ? B_OUT : B_MUL;
                end
            end
            B_OUT:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = (r_state == B_IDLE) && !i_q_empty && !r_out_full;
        div_start = (r_state == B_START);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_out_full <= 1'b0;
            r_axis     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT) begin
                r_out_full <= 1'b1;
            end else if (i_pop && r_out_full) begin
                r_out_full <= 1'b0;
            end
            if (o_q_pop) begin
                r_axis <= 1'b0;
            end else if (r_state == B_WAIT && div_done) begin
                r_axis <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ax    <= i_q_data.avg_x;
            r_ay    <= i_q_data.avg_y;
            r_valid <= in_valid;
            r_px    <= '0;
            r_py    <= '0;
        end
        if (r_state == B_MUL) begin
            r_neg  <= prod[MUL_W-1];
            r_mag  <= prod_abs[MAG_W-1:0];
            r_span <= sel_max - sel_min;
            r_size <= sel_size;
        end
        if (r_state == B_WAIT && div_done) begin
            if (!r_axis) begin
                r_px <= pix[PIX_W-1:0];
            end else begin
                r_py <= pix[PIX_W-1:0];
            end
        end
        if (r_state == B_OUT) begin
            o_touch_valid <= r_valid;
            o_avg_x       <= r_ax;
            o_avg_y       <= r_ay;
            o_screen_x    <= r_px;
            o_screen_y    <= r_py;
        end
    end

    assign o_empty = !r_out_full;

    tac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/touch_average_calibrate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_average_calibrate
// Averages raw touch samples and maps them to calibrated pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): one raw X/Y pair per item with a pen-down flag.
//   A pen-up item clears the partial burst and yields nothing. Every SAMPLES
//   pen-down items yield one result item on the output queue (empty/pop).
//   Result: averages, valid flag, and screen X/Y (both zero when invalid).
//   Timing: full stays low while the non-final items of a burst are taken. The
//   final item of a burst raises full through the reciprocal multiply, then
//   the fix-up and push to a two-entry queue. A valid burst runs through the
//   back end as the queue pop, then per axis a multiply state, a divider
//   load state and the 22-step radix-2 divider and its done flag, then the
//   output load. An invalid burst goes from the queue pop straight to the
//   output load. The result shows on the ports the cycle after the output
//   load.
//   Stalls: a result waits in the output register until popped; the front
//   keeps accepting into the queue meanwhile, and after a final item full
//   stays up while the queue is full.
//   Reset (synchronous, i_rst_n low): sums, counts, queues cleared, and the
//   calibration registers return to their defaults. APB writes are meant
//   for an idle block; pready is always high.
// ----------------------------------------------------------------------------
module touch_average_calibrate (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input queue
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       i_pen_down,
    input  wire logic [tac_pkg::RAW_W-1:0]  i_sample_x,
    input  wire logic [tac_pkg::RAW_W-1:0]  i_sample_y,
    // result queue
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_touch_valid,
    output logic [tac_pkg::RAW_W-1:0]       o_avg_x,
    output logic [tac_pkg::RAW_W-1:0]       o_avg_y,
    output logic [tac_pkg::PIX_W-1:0]       o_screen_x,
    output logic [tac_pkg::PIX_W-1:0]       o_screen_y,
    // APB register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tac_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tac_pkg::DATA_W-1:0] pwdata,
    output logic [tac_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import tac_pkg::*;

    t_cal     r_cal;
    t_reg_idx reg_idx;
    logic     wr_en;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_pair    q_wdata;
    t_pair    q_rdata;

    // ---- register file --------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.h_min  <= RST_H_MIN;
            r_cal.h_max  <= RST_H_MAX;
            r_cal.v_min  <= RST_V_MIN;
            r_cal.v_max  <= RST_V_MAX;
            r_cal.width  <= RST_WIDTH;
            r_cal.height <= RST_HEIGHT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_H_MIN:  r_cal.h_min  <= pwdata[RAW_W-1:0];
                REG_H_MAX:  r_cal.h_max  <= pwdata[RAW_W-1:0];
                REG_V_MIN:  r_cal.v_min  <= pwdata[RAW_W-1:0];
                REG_V_MAX:  r_cal.v_max  <= pwdata[RAW_W-1:0];
                REG_WIDTH:  r_cal.width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_cal.height <= pwdata[SIZE_W-1:0];
                default:    ;  // unmapped index: ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_H_MIN:  prdata = DATA_W'(r_cal.h_min);
            REG_H_MAX:  prdata = DATA_W'(r_cal.h_max);
            REG_V_MIN:  prdata = DATA_W'(r_cal.v_min);
            REG_V_MAX:  prdata = DATA_W'(r_cal.v_max);
            REG_WIDTH:  prdata = DATA_W'(r_cal.width);
            REG_HEIGHT: prdata = DATA_W'(r_cal.height);
            default:    prdata = '0;
        endcase
    end

    // ---- front: accumulate and average ------------------------------------
    tac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_pen_down (i_pen_down),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata),
        .i_q_full   (q_full)
    );

    // ---- decoupling queue ------------------------------------------------
    tac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // ---- back: check, scale, invert, clamp, hold result -------------------
    tac_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cal         (r_cal),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_touch_valid (o_touch_valid),
        .o_avg_x       (o_avg_x),
        .o_avg_y       (o_avg_y),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y)
    );

    // ---- checks -------------------------------------------------------------
    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("average pushed into full queue");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("back popped empty queue");

    // an invalid touch carries zero coordinates
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_touch_valid) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("invalid result with nonzero coordinates");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for touch_average_calibrate. Sample bursts with pen
// lifts, stray pen-up items and random raw values go in through the input
// queue. The calibration is swept over the APB port, including degenerate
// spans and out-of-range screen sizes. Both queues idle at random. Every
// result item is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module tb;
    import tac_pkg::*;

    localparam int STALL_LIMIT     = 5000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES   = 100;   // lets the back end finish a burst
    localparam int HOLD_OFF_CYCLES = 600;   // long receiver stall, fills the block
    localparam int MAX_REPORTS     = 10;

    // Register index with no register behind it; writes must be ignored
    localparam t_reg_idx REG_SPARE = 3'd6;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                push       = 1'b0;
    logic                full;
    logic                i_pen_down = 1'b0;
    logic [RAW_W-1:0]    i_sample_x = '0;
    logic [RAW_W-1:0]    i_sample_y = '0;
    logic                empty;
    logic                pop        = 1'b0;
    logic                o_touch_valid;
    logic [RAW_W-1:0]    o_avg_x;
    logic [RAW_W-1:0]    o_avg_y;
    logic [PIX_W-1:0]    o_screen_x;
    logic [PIX_W-1:0]    o_screen_y;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [DATA_W-1:0]   pwdata     = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Idling controls, changed by the stimulus between phases
    bit push_gaps_on = 1'b1;
    bit pop_gaps_on  = 1'b1;
    int drain_hold   = 0;   // >0: receiver stalls this many cycles once

    touch_average_calibrate DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_pen_down    (i_pen_down),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .empty         (empty),
        .pop           (pop),
        .o_touch_valid (o_touch_valid),
        .o_avg_x       (o_avg_x),
        .o_avg_y       (o_avg_y),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Expected touch points
    // ------------------------------------------------------------------------
    typedef struct packed {
        bit               valid;
        bit [RAW_W-1:0]   avg_x;
        bit [RAW_W-1:0]   avg_y;
        bit [PIX_W-1:0]   screen_x;
        bit [PIX_W-1:0]   screen_y;
    } t_touch_point;

    // Mirrors the burst accumulator and the calibration registers, and keeps
    // the touch points still owed by the block, oldest first.
    class t_point_tracker;
        bit [RAW_W-1:0]  h_min, h_max, v_min, v_max;
        bit [SIZE_W-1:0] width, height;
        bit [SUM_W-1:0]  sum_x, sum_y;
        int              taken;
        t_touch_point    pending_points[$];
        int              faults;

        function new();
            h_min  = RST_H_MIN;
            h_max  = RST_H_MAX;
            v_min  = RST_V_MIN;
            v_max  = RST_V_MAX;
            width  = RST_WIDTH;
            height = RST_HEIGHT;
            sum_x  = '0;
            sum_y  = '0;
            taken  = 0;
            faults = 0;
        endfunction

        // Register write as the block sees it: masked to the register width
        function void write_reg(bit [ADDR_W-1:0] addr, bit [DATA_W-1:0] data);
            case (t_reg_idx'(addr[ADDR_W-1:2]))
                REG_H_MIN:  h_min  = data[RAW_W-1:0];
                REG_H_MAX:  h_max  = data[RAW_W-1:0];
                REG_V_MIN:  v_min  = data[RAW_W-1:0];
                REG_V_MAX:  v_max  = data[RAW_W-1:0];
                REG_WIDTH:  width  = data[SIZE_W-1:0];
                REG_HEIGHT: height = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // 0 px acts as 1, oversize clamps to 1024
        function int pixels_for(bit [SIZE_W-1:0] s);
            if (s == 0) return 1;
            if (s > 1024) return 1024;
            return int'(s);
        endfunction

        // Linear scale (signed, truncating), invert, clamp to 0..px-1
        function bit [PIX_W-1:0] place_on_axis(int avg, int lo, int hi, int px);
            int scaled, pos;
            scaled = ((avg - lo) * px) / (hi - lo);
            pos = px - scaled;
            if (pos < 0) pos = 0;
            if (pos >= px) pos = px - 1;
            return PIX_W'(pos);
        endfunction

        function void take_sample(bit pen, bit [RAW_W-1:0] sx, bit [RAW_W-1:0] sy);
            t_touch_point pt;
            if (!pen) begin
                // pen lifted: partial burst is dropped
                sum_x = '0;
                sum_y = '0;
                taken = 0;
                return;
            end
            sum_x += sx;
            sum_y += sy;
            if (taken + 1 < SAMPLES) begin
                taken++;
                return;
            end
            pt.avg_x = RAW_W'(sum_x / SAMPLES);
            pt.avg_y = RAW_W'(sum_y / SAMPLES);
            sum_x = '0;
            sum_y = '0;
            taken = 0;
            pt.valid = pt.avg_x != 0 && pt.avg_y != 0
                       && pt.avg_x <= AVG_LIMIT && pt.avg_y <= AVG_LIMIT
                       && h_max > h_min && v_max > v_min;
            pt.screen_x = '0;
            pt.screen_y = '0;
            if (pt.valid) begin
                // screen X follows raw Y, screen Y follows raw X
                pt.screen_x = place_on_axis(int'(pt.avg_y), int'(h_min), int'(h_max),
                                            pixels_for(width));
                pt.screen_y = place_on_axis(int'(pt.avg_x), int'(v_min), int'(v_max),
                                            pixels_for(height));
            end
            pending_points.push_back(pt);
        endfunction

        function void check_point(t_touch_point got);
            t_touch_point want;
            if (pending_points.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected result: v=%0d ax=%0d ay=%0d sx=%0d sy=%0d",
                             got.valid, got.avg_x, got.avg_y, got.screen_x, got.screen_y);
                return;
            end
            want = pending_points.pop_front();
            if (got.valid != want.valid || got.avg_x != want.avg_x
                || got.avg_y != want.avg_y || got.screen_x != want.screen_x
                || got.screen_y != want.screen_y) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("mismatch: expected v=%0d ax=%0d ay=%0d sx=%0d sy=%0d, %s%0d %0d %0d %0d %0d",
                             want.valid, want.avg_x, want.avg_y, want.screen_x,
                             want.screen_y, "actual ", got.valid, got.avg_x,
                             got.avg_y, got.screen_x, got.screen_y);
            end
        endfunction

        function int pending();
            return pending_points.size();
        endfunction
    endclass

    t_point_tracker tracker = new();

    // ------------------------------------------------------------------------
    // Monitor: all handshakes sampled on the pre-edge values
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                tracker.take_sample(i_pen_down, i_sample_x, i_sample_y);
            if (pop && !empty)
                tracker.check_point('{o_touch_valid, o_avg_x, o_avg_y,
                                      o_screen_x, o_screen_y});
            if (psel && penable && pwrite && pready)
                tracker.write_reg(paddr, pwdata);
        end
    end

    // Watchdog: ends the run if nothing moves on any port for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Mostly no gap, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: pops with random gaps; honors a one-off long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_drain
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (drain_hold > 0) begin
                gap = drain_hold;
                drain_hold = 0;
            end else begin
                gap = pop_gaps_on ? pick_gap() : 0;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (!(pop && !empty));
        end
    end

    // ------------------------------------------------------------------------
    // Sender and register tasks
    // ------------------------------------------------------------------------
    // push stays high across back-to-back items; it only drops for a gap
    task automatic send_sample(bit pen, bit [RAW_W-1:0] sx, bit [RAW_W-1:0] sy);
        int gap;
        gap = push_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_pen_down <= pen;
        i_sample_x <= sx;
        i_sample_y <= sy;
        do @(posedge i_clk); while (!(push && !full));
    endtask

    // SAMPLES identical pairs: the average is exactly the sample
    task automatic send_burst(bit [RAW_W-1:0] sx, bit [RAW_W-1:0] sy);
        repeat (SAMPLES) send_sample(1'b1, sx, sy);
    endtask

    // Sender pauses until every owed result is out, then lets the back end
    // finish anything that produces no result
    task automatic wait_idle();
        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready; upper bits sometimes
    // carry junk to exercise the width masking
    task automatic reg_write(t_reg_idx idx, int value, int bits);
        bit [DATA_W-1:0] data;
        data = DATA_W'(value);
        if ($urandom_range(0, 1))
            data = data | ($urandom << bits);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!(psel && penable && pready));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_cal(int hmin, int hmax, int vmin, int vmax, int w, int h);
        wait_idle();
        reg_write(REG_H_MIN,  hmin, RAW_W);
        reg_write(REG_H_MAX,  hmax, RAW_W);
        reg_write(REG_V_MIN,  vmin, RAW_W);
        reg_write(REG_V_MAX,  vmax, RAW_W);
        reg_write(REG_WIDTH,  w,    SIZE_W);
        reg_write(REG_HEIGHT, h,    SIZE_W);
    endtask

    // Screen size: mostly legal, with zero, 1024 and oversize thrown in
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 1024;
        if (r == 2) return $urandom_range(1025, 2047);
        return $urandom_range(1, 1024);
    endfunction

    task automatic random_cal();
        int a, b, c, d, t;
        a = $urandom_range(0, 4095);
        b = $urandom_range(0, 4095);
        c = $urandom_range(0, 4095);
        d = $urandom_range(0, 4095);
        // most settings are sane; some keep a reversed span
        if (a > b && $urandom_range(0, 4) != 0) begin
            t = a; a = b; b = t;
        end
        if (c > d && $urandom_range(0, 4) != 0) begin
            t = c; c = d; d = t;
        end
        apply_cal(a, b, c, d, pick_size(), pick_size());
    endtask

    // Burst center: near the valid-average limits, near the calibration
    // limits, or anywhere
    function automatic int pick_center();
        int r, base;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom_range(0, 3);
        if (r < 16) return $urandom_range(AVG_LIMIT - 2, 4095);
        if (r < 34) begin
            case ($urandom_range(0, 3))
                0: base = tracker.h_min;
                1: base = tracker.h_max;
                2: base = tracker.v_min;
                default: base = tracker.v_max;
            endcase
            return base + int'($urandom_range(0, 16)) - 8;
        end
        return $urandom_range(0, 4095);
    endfunction

    function automatic bit [RAW_W-1:0] near(int center, int amp);
        int v;
        v = center + int'($urandom_range(0, 2 * amp)) - amp;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return RAW_W'(v);
    endfunction

    // Mostly whole bursts around a center; some wild bursts, some cut short
    // by a pen lift, and a few stray pen-up items
    task automatic random_traffic(int n_items);
        int sent, kind, len, amp, cx, cy, k;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            cx   = pick_center();
            cy   = pick_center();
            amp  = $urandom_range(0, 3);
            if (kind < 8) begin
                send_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom));
                sent++;
            end else begin
                len = (kind < 20) ? $urandom_range(1, SAMPLES - 1) : SAMPLES;
                for (k = 0; k < len; k++) begin
                    if (kind < 35)
                        send_sample(1'b1, RAW_W'($urandom), RAW_W'($urandom));
                    else
                        send_sample(1'b1, near(cx, amp), near(cy, amp));
                    sent++;
                end
                if (len < SAMPLES) begin
                    send_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int i;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, on the reset calibration
        send_burst(12'd0, 12'd0);           // zero average: invalid
        send_burst(12'd4095, 12'd4095);     // above the valid limit
        send_burst(12'd1, 12'd4090);        // both ends of the valid range,
                                            // off both calibration ends
        send_burst(12'd4091, 12'd1);        // just past the limit on X
        // pen lifted mid-burst: the partial sums must be dropped
        send_sample(1'b1, 12'd4095, 12'd0);
        send_sample(1'b1, 12'd0, 12'd4095);
        send_sample(1'b0, 12'd4095, 12'd4095);
        send_burst(12'd2000, 12'd1500);
        random_traffic(200);

        // Full raw range, largest screen
        apply_cal(0, 4095, 0, 4095, 1024, 1024);
        random_traffic(150);

        // Spans of one and three counts (big quotients); zero width acts as 1, oversize
        // height as 1024; the spare register index must change nothing
        apply_cal(2000, 2001, 1000, 1003, 0, 2047);
        reg_write(REG_SPARE, 12'hABC, RAW_W);
        random_traffic(150);

        // Degenerate horizontal span, then reversed vertical span
        apply_cal(1000, 1000, 300, 3800, 320, 240);
        random_traffic(100);
        apply_cal(200, 3750, 3801, 3800, 1, 1);
        random_traffic(100);

        // Receiver stalls for a long stretch while the sender keeps going
        // flat out, so the output queue fills and full comes up
        random_cal();
        push_gaps_on = 1'b0;
        drain_hold   = HOLD_OFF_CYCLES;
        random_traffic(60);
        push_gaps_on = 1'b1;

        // Random calibrations; one phase runs with no idling at all, one
        // with only the sender idling
        for (i = 0; i < 6; i++) begin
            random_cal();
            push_gaps_on = (i != 2);
            pop_gaps_on  = (i != 2) && (i != 4);
            random_traffic(160);
        end

        push <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.faults == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
